@@ rtl/mne_pkg.sv @@
`default_nettype none

package mne_pkg;

  // Image geometry limits and field widths.
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned ID_W       = 20;
  localparam int unsigned CH_W       = 8;

  // Configuration register map.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Node counter saturates here.
  localparam logic [ID_W-1:0] ID_MAX = '1;

  // Result queue geometry; the depth must be a power of two.
  localparam int unsigned RQ_DEPTH = 8;
  localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W = RQ_PTR_W + 1;

  typedef enum logic [1:0] {
    KIND_START    = 2'd0,
    KIND_INTERIOR = 2'd1,
    KIND_END      = 2'd2
  } kind_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [ID_W-1:0]  node_id;
    logic [ROW_W-1:0] node_row;
    logic [COL_W-1:0] node_col;
    kind_e            kind;
    logic             has_up;
    logic [ID_W-1:0]  up_id;
    logic             has_left;
    logic [ID_W-1:0]  left_id;
    logic             id_overflow;
    logic             last;
  } node_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } link_t;

  // Write control of the result queue: push1 is only set together with push0.
  typedef struct packed {
    logic push0;
    logic push1;
  } rq_push_t;

  localparam link_t LINK_NONE = '{valid: 1'b0, id: '0};

  // Clamps a dimension register to [3, hi] and returns the last index.
  function automatic logic [DIM_W-1:0] dim_last(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] c;
    if (v < DIM_W'(3)) begin
      c = DIM_W'(3);
    end else if (v > hi) begin
      c = hi;
    end else begin
      c = v;
    end
    return c - DIM_W'(1);
  endfunction

  function automatic logic [ID_W-1:0] id_next(input logic [ID_W-1:0] id);
    return (id == ID_MAX) ? id : id + ID_W'(1);
  endfunction

  function automatic logic [ID_W-1:0] link_id(input link_t lk);
    return lk.valid ? lk.id : '0;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mne_ram.sv @@
`default_nettype none

module mne_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/mne_rq.sv @@
`default_nettype none

module mne_rq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mne_pkg::rq_push_t              push_i,
  input  mne_pkg::node_t                 item0_i,
  input  mne_pkg::node_t                 item1_i,
  output logic                           valid_o,
  input  logic                           stall_i,
  output mne_pkg::node_t                 item_o,
  output logic [mne_pkg::RQ_CNT_W-1:0]   level_o
);

  import mne_pkg::*;

  node_t                mem_q [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [RQ_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [RQ_PTR_W-1:0]  wr_next;
  logic [RQ_CNT_W-1:0]  cnt_q, cnt_d;
  logic                 pop;

  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign level_o = cnt_q;
  assign pop     = valid_o && !stall_i;
  assign wr_next = wr_ptr_q + RQ_PTR_W'(1);

  // Pointers wrap naturally since the depth is a power of two.
  always_comb begin
    wr_ptr_d = wr_ptr_q + RQ_PTR_W'(push_i.push0) + RQ_PTR_W'(push_i.push1);
    rd_ptr_d = rd_ptr_q + RQ_PTR_W'(pop);
    cnt_d    = cnt_q + RQ_CNT_W'(push_i.push0) + RQ_CNT_W'(push_i.push1)
               - RQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_ptr_q] <= item0_i;
    end
    if (push_i.push1) begin
      mem_q[wr_next] <= item1_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/maze_node_extractor.sv @@
// Maze node extractor: turns a raster stream of RGB maze pixels into the
// node records of a junction graph.
// Pixel requests enter on in_valid_i / in_stall_o with in_item_i, one pixel
// per request in raster order. Node records leave on out_valid_o /
// out_stall_i with out_item_o. A request moves on a clock edge with valid
// high and stall low. The configuration channel (cfg_valid_i / cfg_ready_o)
// writes image_width (index 0) or image_height (index 1); a write restarts
// the frame and must only be issued while the block is idle.
// Throughput is one pixel per cycle while the input is not stalled, set by
// one read and one write per cycle on each of the two line memories. A
// record is written into the result queue from the update stage register
// and offered from there. A start node is caused
// by its own pixel, an interior node by the pixel one row down and one
// column right, and the end node by the last pixel of the frame. Only that
// last pixel can cause two records.
// Reset clears the position, the node counter and the link chains; the
// memories need no clearing pass, so a pixel can be accepted right away.
// When the receiver stalls, records collect in an 8-entry queue and the
// input stalls once the queue cannot take the worst case of what is in
// flight.
`default_nettype none

module maze_node_extractor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mne_pkg::pixel_t                in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mne_pkg::node_t                 out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mne_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mne_pkg::DIM_W-1:0]      cfg_data_i
);

  import mne_pkg::*;

  localparam int unsigned RES_W = RQ_CNT_W + 1;

  // Configuration and pixel position.
  logic [COL_W-1:0] wlast_q, wlast_d;
  logic [ROW_W-1:0] hlast_q, hlast_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             cfg_we, cfg_hit;
  logic             accept;
  logic             col_end, row_end, start_rng;
  logic             open_a;

  // Pixel in the read-modify-write stage.
  logic             b_valid_q;
  logic [ROW_W-1:0] b_row_q, b_rm1_q;
  logic [COL_W-1:0] b_col_q, b_cm1_q;
  logic             b_open_q, b_start_rng_q, b_row0_q, b_inter_q;
  logic             b_cfirst_q, b_lastrow_q, b_flast_q;

  // Window of open bits around the pixel under decision.
  logic             top1_q, mid1_q, mid2_q, bot1_q;
  logic [1:0]       lb_rd;
  logic             up_o, dn_o, lf_o, ctr_o, rt_o, is_node;

  // Node bookkeeping.
  logic [ID_W-1:0]  cnt_q, cnt_d, cnt1, end_id;
  link_t            left_q, left_d, left_use;
  logic             end_found_q, end_found_d;
  logic [COL_W-1:0] end_col_q, end_col_d;
  link_t            end_link_q, end_up;
  link_t            cn_rd, new_link, col_post, main_up, main_left, cn_wdata;
  logic [$bits(link_t)-1:0] cn_rd_data;
  logic             cn_we;
  logic [COL_W-1:0] cn_waddr;
  logic             main_v, end_v, cap;
  node_t            main_item, end_item;

  // Result queue.
  rq_push_t         push;
  logic [RQ_CNT_W-1:0] rq_level;
  logic [RES_W-1:0] reserve;

  // ---------------------------------------------------------------------
  // Configuration. Registers hold the last column and row index, clamped.
  // The port takes a write in any cycle; the user keeps it to idle times.
  // ---------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_we && ((cfg_index_i == REG_IMAGE_WIDTH) ||
                                  (cfg_index_i == REG_IMAGE_HEIGHT));

  always_comb begin
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    if (cfg_we) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH: begin
          wlast_d = COL_W'(dim_last(cfg_data_i, DIM_W'(MAX_WIDTH)));
        end
        REG_IMAGE_HEIGHT: begin
          hlast_d = ROW_W'(dim_last(cfg_data_i, DIM_W'(MAX_HEIGHT)));
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input side. Each accepted pixel reads both line memories at once and
  // moves to the update stage in the next cycle. That stage never holds,
  // so the input stalls only when the queue could not absorb the worst
  // case: two records from the stage plus two from the new pixel.
  // ---------------------------------------------------------------------
  assign reserve    = RES_W'(rq_level) + (b_valid_q ? RES_W'(2) : RES_W'(0));
  assign in_stall_o = (reserve > RES_W'(RQ_DEPTH - 2));
  assign accept     = in_valid_i && !in_stall_o;

  assign open_a    = (in_item_i.red != '0) && (in_item_i.green != '0) &&
                     (in_item_i.blue != '0);
  assign col_end   = (col_q == wlast_q);
  assign row_end   = (row_q == hlast_q);
  assign start_rng = (col_q != '0) && (col_q < wlast_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q   <= COL_W'(MAX_WIDTH - 1);
      hlast_q   <= ROW_W'(MAX_HEIGHT - 1);
      col_q     <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
    end else begin
      wlast_q   <= wlast_d;
      hlast_q   <= hlast_d;
      col_q     <= col_d;
      row_q     <= row_d;
      b_valid_q <= accept;
    end
  end

  // Position flags are worked out here so the update stage only compares
  // against the end column.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_row_q       <= row_q;
      b_rm1_q       <= row_q - ROW_W'(1);
      b_col_q       <= col_q;
      b_cm1_q       <= col_q - COL_W'(1);
      b_open_q      <= open_a;
      b_start_rng_q <= start_rng;
      b_row0_q      <= (row_q == '0) && start_rng;
      b_inter_q     <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
      b_cfirst_q    <= (col_q == COL_W'(2));
      b_lastrow_q   <= row_end;
      b_flast_q     <= row_end && col_end;
    end
  end

  // ---------------------------------------------------------------------
  // Line buffer of open bits. Entry c holds the open bits of column c for
  // the two rows above the current one (bit 1 the row just above). The
  // pixel reads its column and writes it back shifted down by one row.
  // Consecutive pixels always touch different columns, so a read never
  // meets a pending write to the same entry.
  // ---------------------------------------------------------------------
  mne_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (b_valid_q),
    .wr_addr_i (b_col_q),
    .wr_data_i ({b_open_q, lb_rd[1]}),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (lb_rd)
  );

  // The decision for the pixel one row up and one column left. Its four
  // neighbors come from the shifted window and the fresh memory read.
  assign up_o  = top1_q;
  assign dn_o  = bot1_q;
  assign lf_o  = mid2_q;
  assign ctr_o = mid1_q;
  assign rt_o  = lb_rd[1];
  assign is_node = ctr_o && ((up_o != dn_o) || (lf_o != rt_o) ||
                             (up_o && dn_o && lf_o && rt_o));

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      top1_q <= lb_rd[0];
      mid1_q <= lb_rd[1];
      mid2_q <= mid1_q;
      bot1_q <= b_open_q;
    end
  end

  // ---------------------------------------------------------------------
  // Column memory: the last node of each column. Row 0 writes every column
  // of the start range before any later row reads it, so stale entries
  // from earlier frames are never seen and no clearing pass is needed.
  // Interior pixels read the column one to their left at acceptance and write it back here.
  // ---------------------------------------------------------------------
  mne_ram #(
    .WIDTH ($bits(link_t)),
    .DEPTH (MAX_WIDTH)
  ) u_column_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cn_we),
    .wr_addr_i (cn_waddr),
    .wr_data_i (cn_wdata),
    .rd_en_i   (accept),
    .rd_addr_i (col_q - COL_W'(1)),
    .rd_data_o (cn_rd_data)
  );

  assign cn_rd    = link_t'(cn_rd_data);
  assign new_link = '{valid: 1'b1, id: cnt_q};
  assign left_use = b_cfirst_q ? LINK_NONE : left_q;
  assign col_post = !ctr_o ? LINK_NONE : (is_node ? new_link : cn_rd);

  assign cn_we    = b_valid_q && (b_row0_q || (b_inter_q && (!ctr_o || is_node)));
  assign cn_waddr = b_row0_q ? b_col_q : b_cm1_q;
  assign cn_wdata = b_row0_q ? link_t'{valid: b_open_q, id: cnt_q} : col_post;

  // The end node links to the final state of its column. That state is
  // settled when the row above the bottom row passes the end column, one
  // pixel after the end column is found, so it is caught in a register.
  assign cap    = b_valid_q && b_lastrow_q && end_found_q && b_inter_q &&
                  (b_cm1_q == end_col_q);
  assign end_up = cap ? col_post : end_link_q;

  always_ff @(posedge clk_i) begin
    if (cap) begin
      end_link_q <= col_post;
    end
  end

  // ---------------------------------------------------------------------
  // Records. A start or interior node comes first, the end node after it.
  // ---------------------------------------------------------------------
  assign main_v = b_valid_q && ((b_row0_q && b_open_q) || (b_inter_q && is_node));
  assign end_v  = b_valid_q && b_flast_q && end_found_q;
  assign cnt1   = id_next(cnt_q);
  assign end_id = main_v ? cnt1 : cnt_q;

  assign main_up   = b_row0_q ? LINK_NONE : cn_rd;
  assign main_left = b_row0_q ? LINK_NONE : left_use;

  always_comb begin
    main_item.node_id     = cnt_q;
    main_item.node_row    = b_row0_q ? '0 : b_rm1_q;
    main_item.node_col    = b_row0_q ? b_col_q : b_cm1_q;
    main_item.kind        = b_row0_q ? KIND_START : KIND_INTERIOR;
    main_item.has_up      = main_up.valid;
    main_item.up_id       = link_id(main_up);
    main_item.has_left    = main_left.valid;
    main_item.left_id     = link_id(main_left);
    main_item.id_overflow = (cnt_q == ID_MAX);
    main_item.last        = !end_v;

    end_item.node_id      = end_id;
    end_item.node_row     = b_row_q;
    end_item.node_col     = end_col_q;
    end_item.kind         = KIND_END;
    end_item.has_up       = end_up.valid;
    end_item.up_id        = link_id(end_up);
    end_item.has_left     = 1'b0;
    end_item.left_id      = '0;
    end_item.id_overflow  = (end_id == ID_MAX);
    end_item.last         = 1'b1;
  end

  assign push.push0 = main_v || end_v;
  assign push.push1 = main_v && end_v;

  // ---------------------------------------------------------------------
  // Node counter, left chain and end search. The last pixel of a frame,
  // like a register write, starts the next frame from scratch.
  // ---------------------------------------------------------------------
  always_comb begin
    cnt_d       = cnt_q;
    left_d      = left_q;
    end_found_d = end_found_q;
    end_col_d   = end_col_q;
    if (cfg_hit || (b_valid_q && b_flast_q)) begin
      cnt_d       = '0;
      left_d      = LINK_NONE;
      end_found_d = 1'b0;
      end_col_d   = '0;
    end else if (b_valid_q) begin
      if (main_v) begin
        cnt_d = cnt1;
      end
      if (b_inter_q) begin
        if (is_node) begin
          left_d = new_link;
        end else if (!ctr_o || b_cfirst_q) begin
          left_d = LINK_NONE;
        end
      end
      if (b_lastrow_q && b_start_rng_q && !end_found_q && b_open_q) begin
        end_found_d = 1'b1;
        end_col_d   = b_col_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      left_q      <= LINK_NONE;
      end_found_q <= 1'b0;
      end_col_q   <= '0;
    end else begin
      cnt_q       <= cnt_d;
      left_q      <= left_d;
      end_found_q <= end_found_d;
      end_col_q   <= end_col_d;
    end
  end

  // Output queue; it parts the update stage from the receiver.
  mne_rq u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item0_i (main_v ? main_item : end_item),
    .item1_i (end_item),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .item_o  (out_item_o),
    .level_o (rq_level)
  );

endmodule

`default_nettype wire

@@ rtl/mne_checker.sv @@
`default_nettype none

module mne_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input mne_pkg::node_t out_item_o
);

  import mne_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled node record changed or vanished");

  a_link_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.has_up || (out_item_o.up_id == '0)) &&
                    (out_item_o.has_left || (out_item_o.left_id == '0)))
    else $error("missing link carries a nonzero id");

  a_start_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_START) |->
      (out_item_o.node_row == '0) && !out_item_o.has_up &&
      !out_item_o.has_left && out_item_o.last)
    else $error("start node off row 0 or with links");

  a_end_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_END) |->
      !out_item_o.has_left && out_item_o.last)
    else $error("end node with a left link or not last");

endmodule

bind maze_node_extractor mne_checker u_mne_checker (.*);

`default_nettype wire

@@ test/tb_maze_node_extractor.sv @@
`timescale 1ns / 100ps

module tb_maze_node_extractor;
  import mne_pkg::*;

  // Pacing of the two channels. In the first mode the pixel sender idles less
  // than the record receiver, in the second the roles swap, and in the last
  // both sides run flat out.
  typedef enum int unsigned {
    PACE_SENDER_IDLES,
    PACE_RECEIVER_IDLES,
    PACE_NO_IDLE
  } pace_e;

  // The watchdog gives up after this many cycles in which no request moves
  // on any channel. The longest correct quiet stretch is the long receiver
  // hold-off below, so this leaves a wide margin.
  localparam int unsigned QUIET_LIMIT  = 3000;
  // Cycles to let pass once nothing is expected any more. A record leaves
  // after its pixel has passed the update stage; this drains pixels with no record.
  localparam int unsigned SETTLE       = 8;
  // Length of the long receiver hold-off that fills the record queue.
  localparam int unsigned HOLD_CYCLES  = 80;
  // Random pixels per pacing mode.
  localparam int unsigned ITEMS_PER_PACE = 430;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;

  logic    in_valid  = 1'b0;
  pixel_t  in_item   = '0;
  logic    in_stall;
  logic    out_valid;
  logic    out_stall = 1'b0;
  node_t   out_item;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data  = '0;

  maze_node_extractor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Pixels waiting to be offered, and node records predicted but not yet seen.
  pixel_t pending_pixels[$];
  node_t  expected_nodes[$];

  pace_e       pace = PACE_SENDER_IDLES;
  logic        hold_trigger = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;

  // ---------------------------------------------------------------------------
  // Node predictor. It keeps its own copy of the three-row window of open
  // bits, the last node of each column, the last node of the current row,
  // the id counter and the raster position, plus the two geometry registers.
  // ---------------------------------------------------------------------------
  bit              open_bits[3*MAX_WIDTH];
  link_t           col_node[MAX_WIDTH];
  link_t           row_left;
  logic [ID_W-1:0] id_count;
  int unsigned     cur_row;
  int unsigned     cur_col;
  bit              end_seen;
  int unsigned     end_column;
  logic [DIM_W-1:0] reg_width  = DIM_W'(4096);
  logic [DIM_W-1:0] reg_height = DIM_W'(4096);

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // A new frame forgets every link, the counter, the position and the end
  // candidate. The open bits stay; they are always rewritten before use.
  function automatic void restart_frame();
    foreach (col_node[i]) col_node[i] = LINK_NONE;
    row_left   = LINK_NONE;
    id_count   = '0;
    cur_row    = 0;
    cur_col    = 0;
    end_seen   = 1'b0;
    end_column = 0;
  endfunction

  function automatic bit pix_open(int unsigned r, int unsigned c);
    if (c >= MAX_WIDTH) return 1'b0;
    return open_bits[(r % 3) * MAX_WIDTH + c];
  endfunction

  // Builds one record and takes the next id. Once the counter has saturated,
  // every further node reuses the top id and carries the overflow flag.
  function automatic node_t make_node(int unsigned row, int unsigned col, kind_e kind,
                                      link_t up, link_t left);
    node_t n;
    n.id_overflow = (id_count == ID_MAX);
    n.node_id     = id_count;
    if (!n.id_overflow) id_count = id_count + 1'b1;
    n.node_row = ROW_W'(row);
    n.node_col = COL_W'(col);
    n.kind     = kind;
    n.has_up   = up.valid;
    n.up_id    = up.valid ? up.id : '0;
    n.has_left = left.valid;
    n.left_id  = left.valid ? left.id : '0;
    n.last     = 1'b0;
    return n;
  endfunction

  function automatic void predict_pixel(pixel_t px);
    int unsigned w, h, r, c, row_now, col_now;
    bit is_op, u, d, l, rt;
    node_t made[$];
    node_t nd;
    w       = clamp_dim(reg_width, MAX_WIDTH);
    h       = clamp_dim(reg_height, MAX_HEIGHT);
    row_now = cur_row;
    col_now = cur_col;
    is_op   = (px.red != 0) && (px.green != 0) && (px.blue != 0);
    if (col_now < MAX_WIDTH) open_bits[(row_now % 3) * MAX_WIDTH + col_now] = is_op;

    // Every open pixel of the top row, away from the side walls, starts a chain.
    if (row_now == 0 && col_now >= 1 && col_now <= w - 2) begin
      if (is_op) begin
        nd = make_node(0, col_now, KIND_START, LINK_NONE, LINK_NONE);
        made.push_back(nd);
        col_node[col_now] = '{valid: 1'b1, id: nd.node_id};
      end else begin
        col_node[col_now].valid = 1'b0;
      end
    end

    // The pixel one row up and one column left now has all four neighbours
    // known. It becomes a node at a corner, a dead end, a T or a crossing;
    // a closed pixel breaks both the row chain and the column chain.
    if (row_now >= 2 && col_now >= 2) begin
      r = row_now - 1;
      c = col_now - 1;
      if (c == 1) row_left.valid = 1'b0;
      if (pix_open(r, c)) begin
        u  = pix_open(r - 1, c);
        d  = pix_open(r + 1, c);
        l  = pix_open(r, c - 1);
        rt = pix_open(r, c + 1);
        if (u != d || l != rt || (u && d && l && rt)) begin
          nd = make_node(r, c, KIND_INTERIOR, col_node[c], row_left);
          made.push_back(nd);
          row_left    = '{valid: 1'b1, id: nd.node_id};
          col_node[c] = '{valid: 1'b1, id: nd.node_id};
        end
      end else begin
        row_left.valid    = 1'b0;
        col_node[c].valid = 1'b0;
      end
    end

    // Only the first open pixel of the bottom row counts as the exit. Its
    // record waits for the last pixel of the frame, behind every interior node.
    if (row_now == h - 1 && col_now >= 1 && col_now <= w - 2 && !end_seen && is_op) begin
      end_seen   = 1'b1;
      end_column = col_now;
    end
    if (row_now == h - 1 && col_now == w - 1 && end_seen) begin
      nd = make_node(row_now, end_column, KIND_END, col_node[end_column % MAX_WIDTH],
                     LINK_NONE);
      made.push_back(nd);
    end

    if (made.size() != 0) made[made.size() - 1].last = 1'b1;
    foreach (made[i]) expected_nodes.push_back(made[i]);

    if (col_now + 1 >= w) begin
      if (row_now + 1 >= h) begin
        restart_frame();
      end else begin
        cur_col = 0;
        cur_row = row_now + 1;
      end
    end else begin
      cur_col = col_now + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers.
  // ---------------------------------------------------------------------------
  function automatic bit roll(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic pixel_t rgb(int unsigned r, int unsigned g, int unsigned b);
    pixel_t p;
    p.red   = CH_W'(r);
    p.green = CH_W'(g);
    p.blue  = CH_W'(b);
    return p;
  endfunction

  // An open pixel has all three channels nonzero. A closed one has at least
  // one zero channel, sometimes all three, with random values elsewhere.
  function automatic pixel_t rand_pixel(bit want_open);
    pixel_t p;
    if (want_open) begin
      p = rgb($urandom_range(255, 1), $urandom_range(255, 1), $urandom_range(255, 1));
    end else begin
      p = rgb($urandom_range(255), $urandom_range(255), $urandom_range(255));
      case ($urandom_range(3))
        0: p.red   = '0;
        1: p.green = '0;
        2: p.blue  = '0;
        default: p = '0;
      endcase
    end
    return p;
  endfunction

  // Queues the first count pixels of a w x h maze. The outer ring is mostly
  // wall, as in a real maze, so that the interior rules get exercised.
  task automatic queue_frame(int unsigned w, int unsigned h, int unsigned pct,
                             int unsigned count);
    int unsigned k, r, c;
    bit want_open;
    for (k = 0; k < count; k++) begin
      r = k / w;
      c = k % w;
      if (c == 0 || c == w - 1)
        want_open = roll(pct / 4);
      else if (r == 0 || r == h - 1)
        want_open = roll(pct / 2);
      else
        want_open = roll(pct);
      pending_pixels.push_back(rand_pixel(want_open));
    end
  endtask

  // Returns once every queued pixel has gone in and every predicted record
  // has come out, then lets the pipeline drain pixels that made no record.
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_pixels.size() != 0 || in_valid || expected_nodes.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // One register write on the configuration channel. The predictor takes
  // the new value at the same edge, and the write starts a fresh frame.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) reg_width = value;
    else reg_height = value;
    restart_frame();
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Pixel driver. A pixel request moves when valid is high and stall is low
  // at the edge; the predictor sees it at that same edge. A new pixel is only
  // put up when the current one has gone, so a stalled payload holds still.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : pixel_driver
    int unsigned gap_pct;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      gap_pct = (pace == PACE_SENDER_IDLES) ? 24 : (pace == PACE_RECEIVER_IDLES) ? 56 : 0;
      if (in_valid && !in_stall) predict_pixel(in_item);
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() != 0 && !roll(gap_pct)) begin
          in_valid <= 1'b1;
          in_item  <= pending_pixels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic bit field_bad(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: node record mismatch in %s: expected %0h, actual %0h",
               $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Record monitor. Every accepted record is checked field by field against
  // the oldest prediction. The same block drives the stall: random stalls by
  // pace, or a long hold-off counted here once the stimulus asks for one.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : node_monitor
    node_t want;
    bit bad;
    int unsigned stall_pct;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_nodes.size() == 0) begin
          $display("%0t: unexpected node record: expected none, actual %h", $time, out_item);
          mismatch_count++;
        end else begin
          want = expected_nodes.pop_front();
          bad  = field_bad("node_id", 32'(want.node_id), 32'(out_item.node_id));
          bad |= field_bad("node_row", 32'(want.node_row), 32'(out_item.node_row));
          bad |= field_bad("node_col", 32'(want.node_col), 32'(out_item.node_col));
          bad |= field_bad("kind", 32'(want.kind), 32'(out_item.kind));
          bad |= field_bad("has_up", 32'(want.has_up), 32'(out_item.has_up));
          bad |= field_bad("up_id", 32'(want.up_id), 32'(out_item.up_id));
          bad |= field_bad("has_left", 32'(want.has_left), 32'(out_item.has_left));
          bad |= field_bad("left_id", 32'(want.left_id), 32'(out_item.left_id));
          bad |= field_bad("id_overflow", 32'(want.id_overflow),
                           32'(out_item.id_overflow));
          bad |= field_bad("last", 32'(want.last), 32'(out_item.last));
          if (bad) mismatch_count++;
        end
      end
      stall_pct = (pace == PACE_SENDER_IDLES) ? 56 : (pace == PACE_RECEIVER_IDLES) ? 24 : 0;
      if (hold_trigger != hold_seen) begin
        hold_seen <= hold_trigger;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= roll(stall_pct);
      end
    end
  end

  // Watchdog: a run in which no request moves for too long is a hang.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. A short directed part at the smallest geometry, then the two
  // geometry extremes as partial frames, then random mazes under each pacing.
  // Geometry is only rewritten when the block has gone quiet.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    pace_e       paces[3];
    int unsigned w, h, pct, frames, count, sent, half;
    paces = '{PACE_SENDER_IDLES, PACE_RECEIVER_IDLES, PACE_NO_IDLE};
    restart_frame();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Values below three clamp to the smallest 3 x 3 image.
    write_reg(REG_IMAGE_WIDTH, DIM_W'(0));
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(2));

    // All open: one start node, a four-way crossing in the middle that links
    // up to it, and the exit under it. Channel extremes ride along.
    pending_pixels.push_back(rgb(255, 255, 255));
    pending_pixels.push_back(rgb(1, 1, 1));
    pending_pixels.push_back(rgb(128, 64, 32));
    pending_pixels.push_back(rgb(1, 255, 1));
    pending_pixels.push_back(rgb(170, 85, 255));
    pending_pixels.push_back(rgb(255, 1, 255));
    pending_pixels.push_back(rgb(2, 4, 8));
    pending_pixels.push_back(rgb(254, 253, 127));
    pending_pixels.push_back(rgb(16, 32, 64));
    // Closed top gap and closed bottom row: the middle node is a dead end
    // with neither an up nor a left link, and with no open exit pixel no end
    // node appears.
    pending_pixels.push_back(rgb(255, 255, 255));
    pending_pixels.push_back(rgb(255, 0, 255));
    pending_pixels.push_back(rgb(9, 9, 9));
    pending_pixels.push_back(rgb(200, 100, 50));
    pending_pixels.push_back(rgb(3, 7, 5));
    pending_pixels.push_back(rgb(0, 0, 0));
    pending_pixels.push_back(rgb(255, 255, 0));
    pending_pixels.push_back(rgb(0, 255, 255));
    pending_pixels.push_back(rgb(0, 0, 0));
    wait_quiet();

    // Widest image, clamped down from the top of the register range. The top
    // row is mostly open so nearly every pixel makes a start node; the long
    // hold-off on the receiver fills the record queue and stalls the input.
    write_reg(REG_IMAGE_WIDTH, DIM_W'(8191));
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(3));
    @(posedge clk_i);
    hold_trigger <= ~hold_trigger;
    @(negedge clk_i);
    for (int k = 0; k < 160; k++) pending_pixels.push_back(rand_pixel(roll(85)));
    wait_quiet();

    // Narrowest and tallest image, cut short by the next register write.
    write_reg(REG_IMAGE_WIDTH, DIM_W'(3));
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(4096));
    queue_frame(3, 4096, 70, 120);
    wait_quiet();

    foreach (paces[p]) begin
      @(posedge clk_i);
      pace <= paces[p];
      @(negedge clk_i);
      sent = 0;
      while (sent < ITEMS_PER_PACE) begin
        w = roll(12) ? $urandom_range(48, 17) : $urandom_range(12, 3);
        h = roll(12) ? $urandom_range(24, 13) : $urandom_range(9, 3);
        write_reg(REG_IMAGE_WIDTH, DIM_W'(w));
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(h));
        frames = $urandom_range(3, 1);
        for (int f = 0; f < frames; f++) begin
          if (sent >= ITEMS_PER_PACE) break;
          pct   = roll(80) ? $urandom_range(85, 55) : $urandom_range(95, 10);
          count = w * h;
          // Now and then a frame is left unfinished; the next write restarts it.
          if (f == frames - 1 && roll(20)) count = $urandom_range(w * h - 1, 1);
          // The last frame of a pacing mode is cut to the remaining budget.
          if (count > ITEMS_PER_PACE - sent) count = ITEMS_PER_PACE - sent;
          if (paces[p] == PACE_NO_IDLE && f == 0) begin
            // The sender stops halfway through the frame until every record
            // so far has arrived, then finishes it.
            half = count / 2;
            queue_frame(w, h, pct, half);
            wait_quiet();
            for (int k = half; k < count; k++)
              pending_pixels.push_back(rand_pixel(roll(pct)));
          end else begin
            queue_frame(w, h, pct, count);
          end
          sent += count;
        end
        wait_quiet();
      end
    end

    wait_quiet();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatch_count == 0 && expected_nodes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
